>>> rtl/nfa_pkg.sv
// ----------------------------------------------------------------------------
// nfa_pkg: shared types and constants for the NFA character matcher
// Command and status codes, edge table entry type, default sizes.
// ----------------------------------------------------------------------------
package nfa_pkg;

   localparam int NUM_STATES_DEF = 16;
   localparam int NUM_EDGES_DEF  = 32;

   localparam int STATE_IDX_W = 4;   // width of from/to state fields
   localparam int CHAR_W      = 8;
   localparam int ACTIVE_W    = 16;  // visible part of the active set

   // command codes
   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_STEP   = 2'd1;
   localparam logic [1:0] CMD_RESET  = 2'd2;
   localparam logic [1:0] CMD_REVERT = 2'd3;

   // add-edge status codes
   localparam logic [1:0] ADD_OK     = 2'd0;
   localparam logic [1:0] ADD_NO_SRC = 2'd1;
   localparam logic [1:0] ADD_FULL   = 2'd2;

   typedef struct packed {
      logic [STATE_IDX_W-1:0] src;
      logic [STATE_IDX_W-1:0] dst;
      logic [CHAR_W-1:0]      ch;
      logic                   neg;
   } edge_type;

endpackage

>>> rtl/nfa_char_matcher.sv
// ----------------------------------------------------------------------------
// nfa_char_matcher: NFA simulation with epsilon closure
// Edge table in memory, one shared compare unit swept over it by a sequencer.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake           | Word
//  req_     | in        | req_valid/req_stall | cmd, states, edge char, flags, char
//  rsp_     | out       | rsp_valid/rsp_stall | active set, on_goal, dead, status
//
//  Add, reset and revert: after accept the block waits in ST_RESP until the
//  result register is empty or draining, then loads it and returns to idle.
//  A step reads one edge per cycle from the edge memory port: R + 1 closure
//  passes over the E stored edges, R = rounds that grew the set (at most
//  NUM_STATES - 1), then one character pass and the result load in ST_RESP.
//  req_stall is high from accept until the result is loaded; a waiting result
//  does not block the next accept. Synchronous reset: one start state active.
// ----------------------------------------------------------------------------
module nfa_char_matcher #(
   parameter int NUM_STATES = nfa_pkg::NUM_STATES_DEF,
   parameter int NUM_EDGES  = nfa_pkg::NUM_EDGES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request words
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_cmd,
   input  logic [nfa_pkg::STATE_IDX_W-1:0]   req_from_state,
   input  logic [nfa_pkg::STATE_IDX_W-1:0]   req_to_state,
   input  logic [nfa_pkg::CHAR_W-1:0]        req_trans_char,
   input  logic                              req_negate,
   input  logic                              req_goal_flag,
   input  logic [nfa_pkg::CHAR_W-1:0]        req_in_char,
   // response words
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [nfa_pkg::ACTIVE_W-1:0]      rsp_active_set,
   output logic                              rsp_on_goal,
   output logic                              rsp_dead,
   output logic [1:0]                        rsp_add_status
);
   import nfa_pkg::*;

   localparam int SW = $clog2(NUM_STATES);      // state index width
   localparam int EW = $clog2(NUM_EDGES);       // edge address width
   localparam int CW = $clog2(NUM_EDGES + 1);   // edge count width

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLOS,   // epsilon closure rounds
      ST_CHAR,   // character edge pass
      ST_RESP    // load result register
   } state_type;

   state_type             state_ff;

   // automaton state
   logic [CW-1:0]         count_ff;
   logic [NUM_STATES-1:0] exists_ff;
   logic [NUM_STATES-1:0] goal_ff;
   logic [NUM_STATES-1:0] active_ff;
   logic [NUM_STATES-1:0] prev_ff;

   // scan datapath
   logic [NUM_STATES-1:0] work_ff;     // closure under construction
   logic [NUM_STATES-1:0] acc_ff;      // targets of character edges
   logic [CW-1:0]         idx_ff;      // next edge to read
   logic                  rd_vld_ff;   // read data valid this cycle
   logic                  changed_ff;  // closure grew in this round
   logic [CHAR_W-1:0]     in_char_ff;
   logic [1:0]            status_ff;

   // result register
   logic                  rsp_valid_ff;
   logic [ACTIVE_W-1:0]   rsp_active_ff;
   logic                  rsp_on_goal_ff;
   logic                  rsp_dead_ff;
   logic [1:0]            rsp_status_ff;

   logic                  scanning;
   logic                  scan_issue;
   logic                  scan_done;
   logic                  rsp_load;
   logic                  add_wr;
   edge_type              wr_edge;
   edge_type              rd_edge;
   logic [CHAR_W-1:0]     query;
   logic                  hit;
   logic [SW-1:0]         dst_idx;
   logic [SW-1:0]         from_idx;
   logic [SW-1:0]         to_idx;
   logic                  src_ok;
   logic                  dst_ok;
   logic                  tbl_full;

   assign scanning   = (state_ff == ST_CLOS) || (state_ff == ST_CHAR);
   assign scan_issue = scanning && (idx_ff != count_ff);
   assign scan_done  = (idx_ff == count_ff) && !rd_vld_ff;

   // result register takes a new word when empty or draining this cycle
   assign rsp_load   = (state_ff == ST_RESP) && (!rsp_valid_ff || !rsp_stall);

   // add-edge checks; the range test guards the truncated index
   assign from_idx = SW'(req_from_state);
   assign to_idx   = SW'(req_to_state);
   assign src_ok   = (int'(req_from_state) < NUM_STATES) && exists_ff[from_idx];
   assign dst_ok   = int'(req_to_state) < NUM_STATES;
   assign tbl_full = count_ff == CW'(NUM_EDGES);
   assign add_wr   = (state_ff == ST_IDLE) && req_valid && (req_cmd == CMD_ADD)
                     && src_ok && dst_ok && !tbl_full;

   assign wr_edge.src = req_from_state;
   assign wr_edge.dst = req_to_state;
   assign wr_edge.ch  = req_trans_char;
   assign wr_edge.neg = req_negate;

   // closure queries the epsilon character
   assign query = (state_ff == ST_CLOS) ? CHAR_W'(0) : in_char_ff;

   nfa_edge_mem #(
      .NUM_EDGES (NUM_EDGES)
   ) u_mem (
      .clock   (clock),
      .wr_en   (add_wr),
      .wr_addr (count_ff[EW-1:0]),
      .wr_data (wr_edge),
      .rd_en   (scan_issue),
      .rd_addr (idx_ff[EW-1:0]),
      .rd_data (rd_edge)
   );

   nfa_edge_match #(
      .NUM_STATES (NUM_STATES)
   ) u_match (
      .edge_in   (rd_edge),
      .state_set (work_ff),
      .query     (query),
      .hit       (hit),
      .dst_idx   (dst_idx)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         exists_ff    <= NUM_STATES'(1);
         goal_ff      <= '0;
         active_ff    <= NUM_STATES'(1);
         prev_ff      <= '0;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         changed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= scan_issue;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  in_char_ff <= req_in_char;
                  unique case (req_cmd)
                     CMD_ADD: begin
                        state_ff <= ST_RESP;
                        if (!(src_ok && dst_ok)) begin
                           status_ff <= ADD_NO_SRC;
                        end else if (tbl_full) begin
                           status_ff <= ADD_FULL;
                        end else begin
                           status_ff <= ADD_OK;
                           count_ff  <= count_ff + CW'(1);
                           if (!exists_ff[to_idx]) begin
                              exists_ff[to_idx] <= 1'b1;
                              goal_ff[to_idx]   <= req_goal_flag;
                           end
                        end
                     end
                     CMD_STEP: begin
                        status_ff  <= ADD_OK;
                        work_ff    <= active_ff;
                        idx_ff     <= '0;
                        changed_ff <= 1'b0;
                        state_ff   <= ST_CLOS;
                     end
                     CMD_RESET: begin
                        status_ff <= ADD_OK;
                        state_ff  <= ST_RESP;
                        active_ff <= NUM_STATES'(1);
                        prev_ff   <= '0;
                     end
                     CMD_REVERT: begin
                        status_ff <= ADD_OK;
                        state_ff  <= ST_RESP;
                        active_ff <= prev_ff;
                        prev_ff   <= '0;
                     end
                  endcase
               end
            end
            ST_CLOS: begin
               if (scan_issue) begin
                  idx_ff <= idx_ff + CW'(1);
               end
               // in-place update: new states are seen later in the same round
               if (rd_vld_ff && hit && !work_ff[dst_idx]) begin
                  work_ff[dst_idx] <= 1'b1;
                  changed_ff       <= 1'b1;
               end
               if (scan_done) begin
                  idx_ff     <= '0;
                  changed_ff <= 1'b0;
                  if (!changed_ff) begin
                     acc_ff   <= '0;
                     state_ff <= ST_CHAR;
                  end
               end
            end
            ST_CHAR: begin
               if (scan_issue) begin
                  idx_ff <= idx_ff + CW'(1);
               end
               if (rd_vld_ff && hit) begin
                  acc_ff[dst_idx] <= 1'b1;
               end
               if (scan_done) begin
                  prev_ff   <= work_ff;
                  active_ff <= acc_ff;
                  state_ff  <= ST_RESP;
               end
            end
            ST_RESP: begin
               if (rsp_load) begin
                  rsp_active_ff  <= ACTIVE_W'(active_ff);
                  rsp_on_goal_ff <= |(active_ff & goal_ff);
                  rsp_dead_ff    <= active_ff == '0;
                  rsp_status_ff  <= status_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall      = state_ff != ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_active_set = rsp_active_ff;
   assign rsp_on_goal    = rsp_on_goal_ff;
   assign rsp_dead       = rsp_dead_ff;
   assign rsp_add_status = rsp_status_ff;

endmodule

>>> rtl/nfa_edge_mem.sv
// ----------------------------------------------------------------------------
// nfa_edge_mem: edge table storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nfa_edge_mem #(
   parameter int NUM_EDGES = nfa_pkg::NUM_EDGES_DEF
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(NUM_EDGES)-1:0] wr_addr,
   input  nfa_pkg::edge_type            wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(NUM_EDGES)-1:0] rd_addr,
   output nfa_pkg::edge_type            rd_data
);
   import nfa_pkg::*;

   edge_type mem_ff [NUM_EDGES];
   edge_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/nfa_edge_match.sv
// ----------------------------------------------------------------------------
// nfa_edge_match: shared edge compare unit
// Flags an edge whose source is in the set and whose character matches.
// ----------------------------------------------------------------------------
module nfa_edge_match #(
   parameter int NUM_STATES = nfa_pkg::NUM_STATES_DEF
) (
   input  nfa_pkg::edge_type                 edge_in,
   input  logic [NUM_STATES-1:0]             state_set,
   input  logic [nfa_pkg::CHAR_W-1:0]        query,
   output logic                              hit,
   output logic [$clog2(NUM_STATES)-1:0]     dst_idx
);
   import nfa_pkg::*;

   localparam int SW = $clog2(NUM_STATES);

   logic [SW-1:0] src_idx;
   logic          ch_match;

   assign src_idx  = SW'(edge_in.src);
   // negated edge matches every other character
   assign ch_match = edge_in.neg ? (edge_in.ch != query) : (edge_in.ch == query);
   assign hit      = state_set[src_idx] && ch_match;
   assign dst_idx  = SW'(edge_in.dst);

endmodule

>>> rtl/nfa_chk.sv
// ----------------------------------------------------------------------------
// nfa_chk: port checker for the NFA character matcher
// Watches the response channel for consistent result words.
// ----------------------------------------------------------------------------
module nfa_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [nfa_pkg::ACTIVE_W-1:0]    rsp_active_set,
   input logic                            rsp_on_goal,
   input logic                            rsp_dead,
   input logic [1:0]                      rsp_add_status
);
   import nfa_pkg::*;

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_active_set)
         && $stable(rsp_on_goal) && $stable(rsp_dead) && $stable(rsp_add_status))
      else $error("response changed while stalled");

   // a visible active state means not dead
   a_live: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_active_set != '0) |-> !rsp_dead)
      else $error("dead flagged with active states");

   // no goal without an active state
   a_dead_goal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dead |-> !rsp_on_goal)
      else $error("goal reported on dead set");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_add_status == ADD_OK) || (rsp_add_status == ADD_NO_SRC)
         || (rsp_add_status == ADD_FULL))
      else $error("undefined add status");

endmodule

bind nfa_char_matcher nfa_chk u_nfa_chk (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_active_set (rsp_active_set),
   .rsp_on_goal    (rsp_on_goal),
   .rsp_dead       (rsp_dead),
   .rsp_add_status (rsp_add_status)
);

>>> tb/sv/nfa_char_matcher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nfa_char_matcher_tb: self-checking bench for the NFA character matcher
// Builds automata edge by edge, walks them with character steps, resets and
// reverts. A scoreboard predicts every result word and checks it. Both
// handshakes are throttled at random, and there is one long result hold-off.
// ----------------------------------------------------------------------------
import nfa_pkg::*;

localparam int STATE_SLOTS = NUM_STATES_DEF;
localparam int EDGE_SLOTS  = NUM_EDGES_DEF;

typedef logic [STATE_SLOTS-1:0] state_set_type;

typedef struct packed {
   logic [ACTIVE_W-1:0] active_set;
   logic                on_goal;
   logic                dead;
   logic [1:0]          add_status;
} match_word_type;

class nfa_scoreboard;
   edge_type        arcs[EDGE_SLOTS];
   int unsigned     arc_count;
   state_set_type   exists;
   state_set_type   goals;
   state_set_type   active;
   state_set_type   prior;
   match_word_type  waiting[$];
   int              errors;
   // tallies for the end-of-run summary
   int              words, steps, resets, reverts, dead_seen, goal_seen;
   int              add_tally[3];

   function new();
      arc_count = 0;
      exists    = state_set_type'(1);
      goals     = '0;
      active    = state_set_type'(1);
      prior     = '0;
      errors    = 0;
      words     = 0;
      steps     = 0;
      resets    = 0;
      reverts   = 0;
      dead_seen = 0;
      goal_seen = 0;
      add_tally = '{0, 0, 0};
   endfunction

   function int pending();
      return waiting.size();
   endfunction

   function bit arc_hits(edge_type a, logic [CHAR_W-1:0] q);
      return a.neg ? (a.ch != q) : (a.ch == q);
   endfunction

   // targets of every stored arc that leaves the set and matches q
   function state_set_type advance(state_set_type from_set, logic [CHAR_W-1:0] q);
      state_set_type reach;
      int            i;
      reach = '0;
      for (i = 0; i < arc_count; i++)
         if (from_set[arcs[i].src] && arc_hits(arcs[i], q))
            reach[arcs[i].dst] = 1'b1;
      return reach;
   endfunction

   // closure follows query 0, so negated arcs on a nonzero char count too
   function state_set_type eps_closure(state_set_type s);
      state_set_type grown;
      int            r;
      for (r = 0; r < STATE_SLOTS; r++) begin
         grown = s | advance(s, '0);
         if (grown == s)
            break;
         s = grown;
      end
      return s;
   endfunction

   function void note_request(logic [1:0] cmd, logic [STATE_IDX_W-1:0] from_st,
                              logic [STATE_IDX_W-1:0] to_st,
                              logic [CHAR_W-1:0] tch, logic neg, logic goal,
                              logic [CHAR_W-1:0] ch);
      match_word_type w;
      logic [1:0]     status;
      status = ADD_OK;
      words++;
      case (cmd)
         CMD_ADD: begin
            if (!exists[from_st])
               status = ADD_NO_SRC;
            else if (arc_count >= EDGE_SLOTS)
               status = ADD_FULL;
            else begin
               // goal mark only sticks on a newly created target
               if (!exists[to_st]) begin
                  exists[to_st] = 1'b1;
                  if (goal)
                     goals[to_st] = 1'b1;
               end
               arcs[arc_count] = '{src: from_st, dst: to_st, ch: tch, neg: neg};
               arc_count++;
            end
            add_tally[status]++;
         end
         CMD_STEP: begin
            prior  = eps_closure(active);
            active = advance(prior, ch);
            steps++;
         end
         CMD_RESET: begin
            active = state_set_type'(1);
            prior  = '0;
            resets++;
         end
         CMD_REVERT: begin
            active = prior;
            prior  = '0;
            reverts++;
         end
      endcase
      w.active_set = active[ACTIVE_W-1:0];
      w.on_goal    = |(active & goals);
      w.dead       = (active == '0);
      w.add_status = status;
      if (w.dead)
         dead_seen++;
      if (w.on_goal)
         goal_seen++;
      waiting.insert(waiting.size(), w);
   endfunction

   function void check_result(logic [ACTIVE_W-1:0] act, logic og, logic dd,
                              logic [1:0] st);
      match_word_type want;
      if (waiting.size() == 0) begin
         $error("result word with nothing expected: active_set %h", act);
         errors++;
         return;
      end
      want = waiting[0];
      waiting.delete(0);
      if (act !== want.active_set) begin
         $error("active_set: expected %h, got %h", want.active_set, act);
         errors++;
      end
      if (og !== want.on_goal) begin
         $error("on_goal: expected %b, got %b", want.on_goal, og);
         errors++;
      end
      if (dd !== want.dead) begin
         $error("dead: expected %b, got %b", want.dead, dd);
         errors++;
      end
      if (st !== want.add_status) begin
         $error("add_status: expected %0d, got %0d", want.add_status, st);
         errors++;
      end
   endfunction
endclass

module nfa_char_matcher_tb;

   localparam int HOLD_CYCLES  = 1500;  // long result hold-off, fills the block
   localparam int TAIL_CYCLES  = 600;   // beyond a worst-case step
   localparam int PHASE_WORDS  = 150;

   typedef struct {
      logic [1:0]             cmd;
      logic [STATE_IDX_W-1:0] from_state;
      logic [STATE_IDX_W-1:0] to_state;
      logic [CHAR_W-1:0]      trans_char;
      logic                   negate;
      logic                   goal_flag;
      logic [CHAR_W-1:0]      in_char;
   } req_word_type;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_cmd        = CMD_RESET;
   logic [STATE_IDX_W-1:0] req_from_state = '0;
   logic [STATE_IDX_W-1:0] req_to_state   = '0;
   logic [CHAR_W-1:0]      req_trans_char = '0;
   logic                   req_negate     = 1'b0;
   logic                   req_goal_flag  = 1'b0;
   logic [CHAR_W-1:0]      req_in_char    = '0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic [ACTIVE_W-1:0]    rsp_active_set;
   logic                   rsp_on_goal;
   logic                   rsp_dead;
   logic [1:0]             rsp_add_status;

   nfa_scoreboard sb;
   int            rsp_idle_pct = 0;
   bit            hold_start   = 1'b0;
   int            hold_left    = 0;
   req_word_type  script[$];

   nfa_char_matcher dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_from_state (req_from_state),
      .req_to_state   (req_to_state),
      .req_trans_char (req_trans_char),
      .req_negate     (req_negate),
      .req_goal_flag  (req_goal_flag),
      .req_in_char    (req_in_char),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_active_set (rsp_active_set),
      .rsp_on_goal    (rsp_on_goal),
      .rsp_dead       (rsp_dead),
      .rsp_add_status (rsp_add_status)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // both channels sampled at the rising edge; check before note keeps
   // the queue in order even when a result and a word meet on one edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_active_set, rsp_on_goal, rsp_dead, rsp_add_status);
         if (req_valid && !req_stall)
            sb.note_request(req_cmd, req_from_state, req_to_state, req_trans_char,
                            req_negate, req_goal_flag, req_in_char);
      end
   end

   // receiver: random stall, or a counted hold-off when asked for one
   always @(negedge clock) begin
      if (hold_start) begin
         hold_left  = HOLD_CYCLES;
         hold_start = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   function automatic req_word_type arc_word(int f, int t, int c, bit n, bit g);
      req_word_type w;
      w.cmd        = CMD_ADD;
      w.from_state = STATE_IDX_W'(f);
      w.to_state   = STATE_IDX_W'(t);
      w.trans_char = CHAR_W'(c);
      w.negate     = n;
      w.goal_flag  = g;
      w.in_char    = CHAR_W'($urandom());
      return w;
   endfunction

   function automatic req_word_type cmd_word(logic [1:0] cmd, int c);
      req_word_type w;
      w.cmd        = cmd;
      w.from_state = STATE_IDX_W'($urandom());
      w.to_state   = STATE_IDX_W'($urandom());
      w.trans_char = CHAR_W'($urandom());
      w.negate     = 1'($urandom());
      w.goal_flag  = 1'($urandom());
      w.in_char    = CHAR_W'(c);
      return w;
   endfunction

   function automatic void add_to_script(req_word_type w);
      script.insert(script.size(), w);
   endfunction

   // small alphabet so steps actually match, plus epsilon and full range
   function automatic logic [CHAR_W-1:0] pick_char(int zero_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < zero_pct)
         return '0;
      else if (roll < 80)
         return CHAR_W'(8'h61 + $urandom_range(3));
      else
         return CHAR_W'($urandom());
   endfunction

   function automatic int pick_existing();
      int s;
      do s = $urandom_range(STATE_SLOTS - 1);
      while (!sb.exists[s]);
      return s;
   endfunction

   // mostly well-formed adds from reachable states, rarer once the table is full
   function automatic req_word_type random_word();
      req_word_type w;
      int           roll;
      int           add_pct;
      w       = cmd_word(CMD_STEP, $urandom());
      add_pct = (sb.arc_count < EDGE_SLOTS) ? 22 : 6;
      roll    = $urandom_range(99);
      if (roll < add_pct) begin
         w.cmd = CMD_ADD;
         if ($urandom_range(99) < 85)
            w.from_state = STATE_IDX_W'(pick_existing());
         if ($urandom_range(99) < 60)
            w.to_state = STATE_IDX_W'(pick_existing());
         w.trans_char = pick_char(30);
         w.negate     = ($urandom_range(99) < 20);
      end else if (roll < add_pct + 58) begin
         w.in_char = pick_char(10);
      end else if (roll < add_pct + 74) begin
         w.cmd = CMD_RESET;
      end else begin
         w.cmd = CMD_REVERT;
      end
      return w;
   endfunction

   // called at a falling edge; idles first with the given odds
   task automatic send_word(req_word_type w, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= w.cmd;
      req_from_state <= w.from_state;
      req_to_state   <= w.to_state;
      req_trans_char <= w.trans_char;
      req_negate     <= w.negate;
      req_goal_flag  <= w.goal_flag;
      req_in_char    <= w.in_char;
      do @(posedge clock);
      while (req_stall);
   endtask

   task automatic run_random(int n, int req_idle);
      repeat (n) begin
         @(negedge clock);
         send_word(random_word(), req_idle);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   initial begin
      sb = new();

      add_to_script(cmd_word(CMD_STEP, 8'h61));     // no arcs yet: goes dead
      add_to_script(cmd_word(CMD_REVERT, 0));       // back to the start closure
      add_to_script(cmd_word(CMD_REVERT, 0));       // previous was cleared: dead
      add_to_script(cmd_word(CMD_RESET, 0));
      add_to_script(arc_word(5, 1, 8'h61, 0, 0));   // missing source
      add_to_script(arc_word(0, 1, 8'h61, 0, 0));
      add_to_script(arc_word(1, 2, 8'h00, 0, 1));   // epsilon arc
      add_to_script(arc_word(2, 3, 8'h62, 1, 1));   // negated, taken in closure
      add_to_script(arc_word(0, 1, 8'h7a, 0, 1));   // existing target keeps mark
      add_to_script(arc_word(3, 15, 8'hff, 0, 1));
      add_to_script(arc_word(0, 4, 8'h00, 1, 0));   // negated epsilon
      add_to_script(arc_word(15, 10, 8'h80, 0, 0));
      add_to_script(arc_word(10, 0, 8'h00, 0, 0));  // epsilon loop to start
      add_to_script(cmd_word(CMD_STEP, 8'h61));
      add_to_script(cmd_word(CMD_STEP, 8'h00));     // step on char zero
      add_to_script(cmd_word(CMD_STEP, 8'hff));
      add_to_script(cmd_word(CMD_STEP, 8'h80));
      add_to_script(cmd_word(CMD_REVERT, 0));
      add_to_script(cmd_word(CMD_STEP, 8'h62));
      add_to_script(cmd_word(CMD_RESET, 0));
      add_to_script(cmd_word(CMD_REVERT, 0));       // after reset: dead
      add_to_script(cmd_word(CMD_STEP, 8'h7a));
      add_to_script(cmd_word(CMD_STEP, 8'h71));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         @(negedge clock);
         send_word(script[i], 0);
      end
      drain();

      // slow receiver, slow sender, then full speed behind a long hold-off
      rsp_idle_pct = 77;
      run_random(PHASE_WORDS, 14);
      drain();

      rsp_idle_pct = 14;
      run_random(PHASE_WORDS, 77);
      drain();

      rsp_idle_pct = 0;
      hold_start   = 1'b1;
      run_random(PHASE_WORDS, 0);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d words: %0d adds (%0d stored, %0d missing source, %0d table full),",
               sb.words, sb.add_tally[ADD_OK] + sb.add_tally[ADD_NO_SRC] + sb.add_tally[ADD_FULL],
               sb.add_tally[ADD_OK], sb.add_tally[ADD_NO_SRC], sb.add_tally[ADD_FULL]);
      $display("%0d steps, %0d resets, %0d reverts; %0d dead and %0d goal results.",
               sb.steps, sb.resets, sb.reverts, sb.dead_seen, sb.goal_seen);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

>>> files.f
rtl/nfa_pkg.sv
rtl/nfa_edge_mem.sv
rtl/nfa_edge_match.sv
rtl/nfa_char_matcher.sv
rtl/nfa_chk.sv
tb/sv/nfa_char_matcher_tb.sv
